// ===== hw/rtl/ialu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg
// shared types and constants for the integer alu pipeline
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 4;
    localparam int STATUS_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE = 4'd0,
        CMD_ADD  = 4'd1,
        CMD_SUB  = 4'd2,
        CMD_MUL  = 4'd3,
        CMD_DIV  = 4'd4,
        CMD_AND  = 4'd5,
        CMD_OR   = 4'd6,
        CMD_NOT  = 4'd7,
        CMD_XOR  = 4'd8,
        CMD_REM  = 4'd9,
        CMD_INC  = 4'd10,
        CMD_DEC  = 4'd11
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_BADCMD  = 2'd2
    } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ialu_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_div_stage
// one registered restoring-division stage, STEPS quotient bits per stage
// ----------------------------------------------------------------------------
module ialu_div_stage #(
    parameter int W     = 32,
    parameter int STEPS = 4
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] rem_in,
    input  wire logic [W-1:0] quo_in,
    input  wire logic [W-1:0] dvs_in,
    output logic      [W-1:0] rem_out,
    output logic      [W-1:0] quo_out
);
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;
    logic [W-1:0] rem_reg;
    logic [W-1:0] quo_reg;

    always_comb begin
        logic [W:0] trial;
        rem_next = rem_in;
        quo_next = quo_in;
        for (int i = 0; i < STEPS; i++) begin
            trial    = {rem_next, quo_next[W-1]};
            quo_next = {quo_next[W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_in}) begin
                trial       = trial - {1'b0, dvs_in};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/integer_alu_eleven_ops_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_eleven_ops_unit
// signed alu: add sub mul div and or not xor rem inc dec, one result per op
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata {operand_b, operand_a, command}
// m_axis    out  tdata {status, value}
//
// a result passes the decode registers, the divider chain of 4-bit stages
// (DATA_WIDTH rounded up to a multiple of 4) and the output register; one
// transaction per cycle while m_axis is not stalled
// a stall on m_axis freezes the whole pipeline; the output register still
// lets a new transaction in when it is empty
// reset clears the valid bits only
module integer_alu_eleven_ops_unit #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // command, operand_a, operand_b from bit 0 up, zero padded
    input  wire logic [((ialu_pkg::CMD_W + 2*DATA_WIDTH + 7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // value, status from bit 0 up, zero padded
    output logic [((DATA_WIDTH + ialu_pkg::STATUS_W + 7)/8)*8-1:0] m_axis_tdata
);
    import ialu_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int STEPS  = 4;
    localparam int NST    = (W + STEPS - 1) / STEPS;
    localparam int WP     = NST * STEPS;
    localparam int DEPTH  = NST + 2;
    localparam int OUT_W  = ((W + STATUS_W + 7) / 8) * 8;

    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [CMD_W-1:0] cmd_in;
    logic [W-1:0]     a_in;
    logic [W-1:0]     b_in;
    assign cmd_in = s_axis_tdata[CMD_W-1:0];
    assign a_in   = s_axis_tdata[CMD_W +: W];
    assign b_in   = s_axis_tdata[CMD_W+W +: W];

    // stage 0: operation decode, simple ops, magnitudes
    logic [DEPTH-1:0] vld_reg;
    logic [W-1:0]     mul_a_reg, mul_b_reg;
    logic [WP-1:0]    ma_reg, mb_reg;
    logic [CMD_W-1:0] cmd_reg   [DEPTH-1];
    logic             nq_reg    [DEPTH-1];
    logic             nr_reg    [DEPTH-1];
    logic [W-1:0]     sv_reg    [DEPTH-1];

    logic [W-1:0] simp_next, ma_next, mb_next;
    always_comb begin
        simp_next = '0;
        case (cmd_t'(cmd_in))
            CMD_ADD: simp_next = a_in + b_in;
            CMD_SUB: simp_next = a_in - b_in;
            CMD_AND: simp_next = a_in & b_in;
            CMD_OR:  simp_next = a_in | b_in;
            CMD_NOT: simp_next = ~a_in;
            CMD_XOR: simp_next = a_in ^ b_in;
            CMD_INC: simp_next = a_in + W'(1);
            CMD_DEC: simp_next = a_in - W'(1);
            default: simp_next = '0;
        endcase
        ma_next = a_in[W-1] ? (~a_in + W'(1)) : a_in;
        mb_next = b_in[W-1] ? (~b_in + W'(1)) : b_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_a_reg  <= a_in;
            mul_b_reg  <= b_in;
            ma_reg     <= WP'(ma_next);
            mb_reg     <= WP'(mb_next);
            cmd_reg[0] <= cmd_in;
            nq_reg[0]  <= a_in[W-1] ^ b_in[W-1];
            nr_reg[0]  <= a_in[W-1];
            sv_reg[0]  <= simp_next;
            for (int i = 1; i < DEPTH-1; i++) begin
                cmd_reg[i] <= cmd_reg[i-1];
                nq_reg[i]  <= nq_reg[i-1];
                nr_reg[i]  <= nr_reg[i-1];
            end
            // multiply result joins the simple-op lane at sv_reg[1], from the registered operands
            sv_reg[1] <= (cmd_t'(cmd_reg[0]) == CMD_MUL) ? W'(mul_a_reg * mul_b_reg)
                                                          : sv_reg[0];
            for (int i = 2; i < DEPTH-1; i++) begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    // divider chain
    logic [WP-1:0] rem_w [NST+1];
    logic [WP-1:0] quo_w [NST+1];
    logic [WP-1:0] dvs_reg [NST];
    logic [WP-1:0] dvs_w [NST];
    assign rem_w[0] = '0;
    assign quo_w[0] = ma_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dvs_reg[0] <= mb_reg;
            for (int i = 1; i < NST; i++) begin
                dvs_reg[i] <= dvs_reg[i-1];
            end
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_div
        if (g == 0) begin : g_first
            assign dvs_w[g] = mb_reg;
        end else begin : g_rest
            assign dvs_w[g] = dvs_reg[g-1];
        end

        ialu_div_stage #(.W(WP), .STEPS(STEPS)) u_stage (
            .aclk   (aclk),
            .en     (adv),
            .rem_in (rem_w[g]),
            .quo_in (quo_w[g]),
            .dvs_in (dvs_w[g]),
            .rem_out(rem_w[g+1]),
            .quo_out(quo_w[g+1])
        );
    end

    // final stage: sign fix and select, into output register
    logic [CMD_W-1:0] cmd_f;
    logic [W-1:0]     q_f, r_f, val_next;
    logic [STATUS_W-1:0] st_next;
    logic             dz_f;
    assign cmd_f = cmd_reg[DEPTH-2];
    assign q_f   = nq_reg[DEPTH-2] ? (~quo_w[NST][W-1:0] + W'(1)) : quo_w[NST][W-1:0];
    assign r_f   = nr_reg[DEPTH-2] ? (~rem_w[NST][W-1:0] + W'(1)) : rem_w[NST][W-1:0];
    // divisor magnitude zero means divisor zero
    assign dz_f  = (dvs_reg[NST-1] == '0);

    always_comb begin
        val_next = sv_reg[DEPTH-2];
        st_next  = ST_OK;
        case (cmd_t'(cmd_f))
            CMD_DIV: begin
                val_next = dz_f ? '0 : q_f;
                st_next  = dz_f ? ST_DIVZERO : ST_OK;
            end
            CMD_REM: begin
                val_next = dz_f ? '0 : r_f;
                st_next  = dz_f ? ST_DIVZERO : ST_OK;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_AND, CMD_OR, CMD_NOT, CMD_XOR,
            CMD_INC, CMD_DEC: begin
                st_next = ST_OK;
            end
            default: begin
                val_next = '0;
                st_next  = ST_BADCMD;
            end
        endcase
    end

    logic [W-1:0]        val_reg;
    logic [STATUS_W-1:0] st_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            val_reg <= val_next;
            st_reg  <= st_next;
        end
    end

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = OUT_W'({st_reg, val_reg});

    // bad command never comes with a nonzero value
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st_reg == ST_BADCMD |-> val_reg == '0)
        else $error("bad command with nonzero value");
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st_reg == ST_DIVZERO |-> val_reg == '0)
        else $error("divide by zero with nonzero value");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire
